>>> rtl/cmp_pkg.sv
`default_nettype none
package cmp_pkg;

  localparam int MSG_BYTES   = 256;
  localparam int VERB_BYTES  = 16;
  localparam int PARAM_BYTES = 240;

  // Byte counter saturates at MSG_BYTES, so it must be able to hold that value.
  localparam int CNT_W = $clog2(MSG_BYTES + 1);
  localparam int FIELD_MAX = (VERB_BYTES > PARAM_BYTES) ? VERB_BYTES : PARAM_BYTES;
  localparam int FC_W = $clog2(FIELD_MAX);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int RES_DEPTH = 4;
  localparam int RPTR_W = $clog2(RES_DEPTH);

  localparam int ACC_W = 32;
  localparam logic [ACC_W-1:0] SAT_MAG = 32'h8000_0000;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [0:2][0:3][7:0] PREFIX_TEXT = {"CMD ", "RSP ", "IND "};

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_VERB,
    PH_STAT_START,
    PH_STAT_SIGN,
    PH_STAT_DIGITS,
    PH_STAT_SKIP,
    PH_PARAMS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VERB    = 2'd0,
    KIND_PARAM   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MT_CMD = 2'd0,
    MT_RSP = 2'd1,
    MT_IND = 2'd2
  } mtype_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_LENGTH = 2'd2
  } err_t;

  // A byte after classification by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       at_limit;
    logic       is_nul;
    logic       is_space;
    logic       is_digit;
    logic       is_plus;
    logic       is_minus;
    logic [2:0] prefix_mask;
  } cls_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data;
    mtype_t       mtype;
    logic [31:0]  status;
    err_t         err;
    logic         run_last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/cmp_in_if.sv
`default_nettype none
interface cmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/cmp_out_if.sv
`default_nettype none
interface cmp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        item_kind;
  logic [7:0]        out_byte;
  logic [1:0]        message_type;
  logic signed [31:0] status_value;
  logic [1:0]        error_code;
  logic              run_last;

  modport source (output valid, output item_kind, output out_byte, output message_type,
                  output status_value, output error_code, output run_last, input ready);
  modport sink (input valid, input item_kind, input out_byte, input message_type,
                input status_value, input error_code, input run_last, output ready);
endinterface
`default_nettype wire

>>> rtl/cmp_front.sv
`default_nettype none
module cmp_front (
  input  logic          clk,
  input  logic          rst,
  cmp_in_if.sink        msg,
  output cmp_pkg::cls_t item,
  output logic          item_valid,
  input  logic          item_ready
);
  import cmp_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] count_inc;
  logic [2:0]       mask;
  logic             take;
  cls_t             cls;

  assign msg.ready = !item_valid || item_ready;
  assign take = msg.valid && msg.ready;

  // Within the prefix the byte position in the message is the prefix position.
  always_comb begin
    count_inc = (byte_count < CNT_W'(MSG_BYTES)) ? byte_count + 1'b1 : byte_count;
    for (int i = 0; i < 3; i++) begin
      mask[i] = (PREFIX_TEXT[i][byte_count[1:0]] == msg.data_byte);
    end
    cls.data        = msg.data_byte;
    cls.last        = msg.last_byte;
    cls.at_limit    = (count_inc >= CNT_W'(MSG_BYTES));
    cls.is_nul      = (msg.data_byte == 8'h00);
    cls.is_space    = (msg.data_byte == CHAR_SPACE);
    cls.is_digit    = (msg.data_byte >= CHAR_ZERO) && (msg.data_byte <= CHAR_NINE);
    cls.is_plus     = (msg.data_byte == CHAR_PLUS);
    cls.is_minus    = (msg.data_byte == CHAR_MINUS);
    cls.prefix_mask = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      byte_count <= '0;
    end else begin
      if (take) begin
        item_valid <= 1'b1;
        byte_count <= msg.last_byte ? '0 : count_inc;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= cls;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cmp_item_queue.sv
`default_nettype none
module cmp_item_queue (
  input  logic          clk,
  input  logic          rst,
  input  cmp_pkg::cls_t in_item,
  input  logic          in_valid,
  output logic          in_ready,
  output cmp_pkg::cls_t out_item,
  output logic          out_valid,
  input  logic          out_ready
);
  import cmp_pkg::*;

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = (count < (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[head];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cmp_back.sv
`default_nettype none
module cmp_back (
  input  logic          clk,
  input  logic          rst,
  input  cmp_pkg::cls_t item,
  input  logic          item_valid,
  output logic          item_ready,
  cmp_out_if.source     result
);
  import cmp_pkg::*;

  phase_t            phase, phase_next;
  logic [FC_W-1:0]   field_count, field_count_next;
  logic [2:0]        cand, cand_next;
  logic [ACC_W-1:0]  accum, accum_next;
  logic              negative, negative_next;
  logic              digit_seen, digit_seen_next;
  err_t              err_flags, err_flags_next;

  res_t              mem [RES_DEPTH];
  logic [RPTR_W-1:0] head;
  logic [RPTR_W-1:0] tail;
  logic [RPTR_W:0]   count;
  logic              take;
  logic              pop;
  logic              emit;
  kind_t             emit_kind;
  logic [1:0]        n_push;
  res_t              res0;
  res_t              res1;
  res_t              summary;
  logic [35:0]       prod;
  logic [2:0]        mask;
  mtype_t            mtype;
  err_t              err_sum;

  function automatic mtype_t pick_type(input logic [2:0] c);
    if (c[0]) begin
      return MT_CMD;
    end else if (c[1]) begin
      return MT_RSP;
    end
    return MT_IND;
  endfunction

  // Two free entries are needed since one byte can yield a byte and a summary.
  assign item_ready = (count <= (RPTR_W+1)'(RES_DEPTH - 2));
  assign take = item_valid && item_ready;
  assign pop  = result.valid && result.ready;

  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    cand_next        = cand;
    accum_next       = accum;
    negative_next    = negative;
    digit_seen_next  = digit_seen;
    err_flags_next   = err_flags;
    emit             = 1'b0;
    emit_kind        = KIND_VERB;
    mask             = cand & item.prefix_mask;
    prod = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + 36'(item.data[3:0]);

    if (phase != PH_DONE) begin
      if (item.at_limit) begin
        phase_next = PH_DONE;
      end else if (!item.is_nul) begin
        case (phase)
          PH_PREFIX: begin
            cand_next = mask;
            if (mask == 3'b000) begin
              phase_next = PH_DONE;
              if (err_flags == ERR_NONE) err_flags_next = ERR_FORMAT;
            end else if (field_count >= FC_W'(3)) begin
              field_count_next = '0;
              phase_next = PH_VERB;
            end else begin
              field_count_next = field_count + 1'b1;
            end
          end
          PH_VERB: begin
            if (item.is_space) begin
              if (field_count == '0) begin
                phase_next = PH_DONE;
                if (err_flags == ERR_NONE) err_flags_next = ERR_FORMAT;
              end else begin
                field_count_next = '0;
                phase_next = (pick_type(cand) == MT_RSP) ? PH_STAT_START : PH_PARAMS;
              end
            end else if (field_count >= FC_W'(VERB_BYTES - 1)) begin
              phase_next = PH_DONE;
              if (err_flags == ERR_NONE) err_flags_next = ERR_FORMAT;
            end else begin
              field_count_next = field_count + 1'b1;
              emit = 1'b1;
              emit_kind = KIND_VERB;
            end
          end
          PH_STAT_START, PH_STAT_SIGN: begin
            if (item.is_digit) begin
              accum_next = (prod > 36'(SAT_MAG)) ? SAT_MAG : prod[ACC_W-1:0];
              digit_seen_next = 1'b1;
              phase_next = PH_STAT_DIGITS;
            end else if (phase == PH_STAT_START && item.is_minus) begin
              negative_next = 1'b1;
              phase_next = PH_STAT_SIGN;
            end else if (phase == PH_STAT_START && item.is_plus) begin
              phase_next = PH_STAT_SIGN;
            end else begin
              phase_next = PH_DONE;
              if (err_flags == ERR_NONE) err_flags_next = ERR_FORMAT;
            end
          end
          PH_STAT_DIGITS: begin
            if (item.is_digit) begin
              accum_next = (prod > 36'(SAT_MAG)) ? SAT_MAG : prod[ACC_W-1:0];
              digit_seen_next = 1'b1;
            end else if (item.is_space) begin
              phase_next = PH_PARAMS;
            end else begin
              phase_next = PH_STAT_SKIP;
            end
            field_count_next = '0;
          end
          PH_STAT_SKIP: begin
            if (item.is_space) begin
              field_count_next = '0;
              phase_next = PH_PARAMS;
            end
          end
          PH_PARAMS: begin
            if (field_count >= FC_W'(PARAM_BYTES - 1)) begin
              phase_next = PH_DONE;
              if (err_flags == ERR_NONE) err_flags_next = ERR_LENGTH;
            end else begin
              field_count_next = field_count + 1'b1;
              emit = 1'b1;
              emit_kind = KIND_PARAM;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // End of content: a NUL byte, or the final byte while parsing is still open.
    if ((phase != PH_DONE && !item.at_limit && item.is_nul) ||
        (item.last && phase_next != PH_DONE)) begin
      case (phase_next)
        PH_PREFIX, PH_STAT_START, PH_STAT_SIGN: begin
          if (err_flags_next == ERR_NONE) err_flags_next = ERR_FORMAT;
        end
        PH_VERB: begin
          if ((field_count_next == '0 || pick_type(cand_next) == MT_RSP) &&
              err_flags_next == ERR_NONE) begin
            err_flags_next = ERR_FORMAT;
          end
        end
        default: begin
        end
      endcase
      phase_next = PH_DONE;
    end

    err_sum = item.at_limit ? ERR_LENGTH : err_flags_next;
    mtype = pick_type(cand_next);
    summary.kind     = KIND_SUMMARY;
    summary.data     = 8'h00;
    summary.mtype    = MT_CMD;
    summary.status   = 32'h0;
    summary.err      = err_sum;
    summary.run_last = 1'b1;
    if (err_sum == ERR_NONE) begin
      summary.mtype = mtype;
      if (mtype == MT_RSP && digit_seen_next) begin
        if (negative_next) begin
          summary.status = (accum_next >= SAT_MAG) ? 32'h8000_0000 : 32'h0 - accum_next;
        end else begin
          summary.status = (accum_next > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : accum_next;
        end
      end
    end

    res0.kind     = emit_kind;
    res0.data     = item.data;
    res0.mtype    = MT_CMD;
    res0.status   = 32'h0;
    res0.err      = ERR_NONE;
    res0.run_last = 1'b0;
    res1 = summary;
    if (!emit) begin
      res0 = summary;
    end
    n_push = 2'(emit) + 2'(item.last);

    // The summary returns all parse state to its reset value.
    if (item.last) begin
      phase_next       = PH_PREFIX;
      field_count_next = '0;
      cand_next        = 3'b111;
      accum_next       = '0;
      negative_next    = 1'b0;
      digit_seen_next  = 1'b0;
      err_flags_next   = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PREFIX;
      field_count <= '0;
      cand        <= 3'b111;
      accum       <= '0;
      negative    <= 1'b0;
      digit_seen  <= 1'b0;
      err_flags   <= ERR_NONE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
    end else begin
      if (take) begin
        phase       <= phase_next;
        field_count <= field_count_next;
        cand        <= cand_next;
        accum       <= accum_next;
        negative    <= negative_next;
        digit_seen  <= digit_seen_next;
        err_flags   <= err_flags_next;
        tail        <= tail + RPTR_W'(n_push);
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + (take ? (RPTR_W+1)'(n_push) : '0) - (RPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take && n_push != 2'd0) begin
      mem[tail] <= res0;
    end
    if (take && n_push == 2'd2) begin
      mem[tail + 1'b1] <= res1;
    end
  end

  assign result.valid        = (count != '0);
  assign result.item_kind    = mem[head].kind;
  assign result.out_byte     = mem[head].data;
  assign result.message_type = mem[head].mtype;
  assign result.status_value = mem[head].status;
  assign result.error_code   = mem[head].err;
  assign result.run_last     = mem[head].run_last;

endmodule
`default_nettype wire

>>> rtl/control_message_parser.sv
// Path: a byte's result passes the front-end register, the item queue and the result queue
// in order; a summary behind a byte result of the same input is offered once it transfers.
// Throughput: one byte per cycle while results are taken without stall; an input giving a
// byte result and a summary holds two slots of the result queue, limited by its single read port.
// Reset (rst, synchronous): empties all queues and puts the parser in the prefix phase.
`default_nettype none
module control_message_parser (
  input  logic      clk,
  input  logic      rst,
  cmp_in_if.sink    msg,
  cmp_out_if.source result
);
  import cmp_pkg::*;

  cls_t front_item;
  logic front_valid;
  logic front_ready;
  cls_t queue_item;
  logic queue_valid;
  logic queue_ready;

  cmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  cmp_item_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_item   (front_item),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_item  (queue_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready)
  );

  cmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .result     (result)
  );

endmodule
`default_nettype wire
